/* rtl/core/bgd_pkg.sv */
package bgd_pkg;

	localparam int TIME_BITS = 16;
	localparam int CFG_BITS  = 16;

	localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET   = CFG_BITS'(25);
	localparam logic [CFG_BITS-1:0] LONG_PRESS_RESET = CFG_BITS'(1500);
	localparam logic [CFG_BITS-1:0] DOUBLE_GAP_RESET = CFG_BITS'(320);

	typedef enum logic [1:0] {
		GEST_NONE   = 2'd0,
		GEST_SHORT  = 2'd1,
		GEST_LONG   = 2'd2,
		GEST_DOUBLE = 2'd3
	} gesture_t;

	typedef enum logic [1:0] {
		CFG_DEBOUNCE   = 2'd0,
		CFG_LONG_PRESS = 2'd1,
		CFG_DOUBLE_GAP = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [CFG_BITS-1:0] debounce_time;
		logic [CFG_BITS-1:0] long_press_time;
		logic [CFG_BITS-1:0] double_click_gap;
	} cfg_t;

	typedef struct packed {
		logic                 last_raw;
		logic                 stable_level;
		logic                 long_reported;
		logic                 click_pending;
		logic [TIME_BITS-1:0] raw_change_time;
		logic [TIME_BITS-1:0] press_time;
		logic [TIME_BITS-1:0] release_time;
	} btn_state_t;

endpackage

/* rtl/core/bgd_eval.sv */
module bgd_eval (
	input  bgd_pkg::cfg_t                 cfg,
	input  bgd_pkg::btn_state_t           state_cur,
	input  logic [bgd_pkg::TIME_BITS-1:0] now,
	input  logic                          raw,
	output bgd_pkg::btn_state_t           state_nxt,
	output bgd_pkg::gesture_t             gesture
);

	logic [bgd_pkg::TIME_BITS-1:0] since_change;
	logic [bgd_pkg::TIME_BITS-1:0] since_press;
	logic [bgd_pkg::TIME_BITS-1:0] since_release_old;
	logic [bgd_pkg::TIME_BITS-1:0] since_release_new;
	logic [bgd_pkg::TIME_BITS-1:0] change_time;
	logic [bgd_pkg::TIME_BITS-1:0] press_time;
	logic [bgd_pkg::TIME_BITS-1:0] release_time;
	logic                          settle;
	logic                          done;

	// a raw edge restarts the debounce window at this poll
	assign change_time       = (raw != state_cur.last_raw) ? now : state_cur.raw_change_time;
	assign since_change      = now - change_time;
	assign settle            = (raw != state_cur.stable_level) &&
				   (since_change >= cfg.debounce_time);
	assign since_release_old = now - state_cur.release_time;

	// press and release stamps after the settle step
	assign press_time        = (settle && raw) ? now : state_cur.press_time;
	assign release_time      = (settle && !raw && !state_cur.long_reported &&
				    !(state_cur.click_pending &&
				      since_release_old <= cfg.double_click_gap)) ?
				   now : state_cur.release_time;
	assign since_press       = now - press_time;
	assign since_release_new = now - release_time;

	always_comb begin
		state_nxt                 = state_cur;
		state_nxt.last_raw        = raw;
		state_nxt.raw_change_time = change_time;
		state_nxt.press_time      = press_time;
		state_nxt.release_time    = release_time;
		gesture                   = bgd_pkg::GEST_NONE;
		done                      = 1'b0;

		if (settle) begin
			state_nxt.stable_level = raw;
			if (raw) begin
				state_nxt.long_reported = 1'b0;
			end else if (!state_cur.long_reported) begin
				if (state_cur.click_pending && since_release_old <= cfg.double_click_gap) begin
					state_nxt.click_pending = 1'b0;
					gesture                 = bgd_pkg::GEST_DOUBLE;
					done                    = 1'b1;
				end else begin
					state_nxt.click_pending = 1'b1;
				end
			end
		end

		if (!done) begin
			if (state_nxt.stable_level && !state_nxt.long_reported &&
			    since_press >= cfg.long_press_time) begin
				state_nxt.long_reported = 1'b1;
				state_nxt.click_pending = 1'b0;
				gesture                 = bgd_pkg::GEST_LONG;
			end else if (state_nxt.click_pending && !state_nxt.stable_level &&
				     since_release_new > cfg.double_click_gap) begin
				state_nxt.click_pending = 1'b0;
				gesture                 = bgd_pkg::GEST_SHORT;
			end
		end
	end

endmodule

/* rtl/core/button_gesture_detector.sv */
// path: a poll transfer loads the poll register, and event_valid rises when the event register takes it;
// one poll register and one event register
// throughput: one poll per cycle while the event output is not stalled; the state update sits between the two registers
// a stalled event output holds back the poll register and then poll_ready
// reset: asynchronous, active low; button taken as released at time 0, all stamps zero,
// registers back to 25 / 1500 / 320 ms, both pipeline slots empty
module button_gesture_detector (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          poll_valid,
	output logic                          poll_ready,
	input  logic [bgd_pkg::TIME_BITS-1:0] time_ms,
	input  logic                          raw_pressed,
	output logic                          event_valid,
	input  logic                          event_ready,
	output logic [1:0]                    gesture,
	input  logic                          cfg_wr_en,
	input  logic [1:0]                    cfg_idx,
	input  logic [bgd_pkg::CFG_BITS-1:0]  cfg_wdata
);

	logic                          valid_s1;
	logic [bgd_pkg::TIME_BITS-1:0] time_s1;
	logic                          raw_s1;
	logic                          ev_valid_q;
	bgd_pkg::gesture_t             gesture_q;
	bgd_pkg::gesture_t             gesture_nxt;
	bgd_pkg::btn_state_t           state_q;
	bgd_pkg::btn_state_t           state_nxt;
	bgd_pkg::cfg_t                 cfg_q;
	logic                          advance;
	logic                          fire;

	assign advance     = !ev_valid_q || event_ready;
	assign fire        = valid_s1 && advance;
	assign poll_ready  = !valid_s1 || advance;
	assign event_valid = ev_valid_q;
	assign gesture     = gesture_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_time    <= bgd_pkg::DEBOUNCE_RESET;
			cfg_q.long_press_time  <= bgd_pkg::LONG_PRESS_RESET;
			cfg_q.double_click_gap <= bgd_pkg::DOUBLE_GAP_RESET;
		end else if (cfg_wr_en) begin
			unique case (bgd_pkg::cfg_idx_t'(cfg_idx))
				bgd_pkg::CFG_DEBOUNCE:   cfg_q.debounce_time    <= cfg_wdata;
				bgd_pkg::CFG_LONG_PRESS: cfg_q.long_press_time  <= cfg_wdata;
				bgd_pkg::CFG_DOUBLE_GAP: cfg_q.double_click_gap <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// poll register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll_ready) begin
			valid_s1 <= poll_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll_valid && poll_ready) begin
			time_s1 <= time_ms;
			raw_s1  <= raw_pressed;
		end
	end

	bgd_eval u_eval (
		.cfg       (cfg_q),
		.state_cur (state_q),
		.now       (time_s1),
		.raw       (raw_s1),
		.state_nxt (state_nxt),
		.gesture   (gesture_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (fire) begin
			state_q <= state_nxt;
		end
	end

	// event register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_valid_q <= 1'b0;
		end else if (advance) begin
			ev_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			gesture_q <= gesture_nxt;
		end
	end

	a_long_marks_state: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && gesture_q == bgd_pkg::GEST_LONG |-> state_q.long_reported)
		else $error("long press shown without long_reported set");

	a_click_clears_pending: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && (gesture_q == bgd_pkg::GEST_SHORT || gesture_q == bgd_pkg::GEST_DOUBLE)
		|-> !state_q.click_pending && !state_q.stable_level)
		else $error("click shown while click pending or button pressed");

	a_stall_blocks_poll: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && ev_valid_q && !event_ready |-> !poll_ready)
		else $error("poll transfer taken while both stages are stalled");

	a_state_only_on_fire: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(state_q))
		else $error("button state changed without a poll being evaluated");

endmodule
